>>> hdl/stm_pkg.sv
// shared types and constants for the stack trimmed-mean combiner
package stm_pkg;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int SAMPLE_W = 32;
    localparam int FRAC_W = 17;
    localparam int FRAC_SHIFT = 16;
    localparam logic [1:0] REG_MIN_VALID = 2'd0;
    localparam logic [1:0] REG_LOW_FRAC = 2'd1;
    localparam logic [1:0] REG_HIGH_FRAC = 2'd2;
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NO_VALID = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [31:0] MIN_VALID_RST = 32'd256;
    localparam logic [16:0] LOW_FRAC_RST = 17'd0;
    localparam logic [16:0] HIGH_FRAC_RST = 17'd65536;

    typedef struct packed {
        logic ins;
        logic shf;
    } stm_ctl_t;
endpackage

>>> hdl/stm_cell.sv
// one cell of the sorted sample chain: insert in place or shift toward the head
module stm_cell (
    input  logic                            aclk,
    input  stm_pkg::stm_ctl_t               ctl,
    input  logic                            occ,
    input  logic                            tail,
    input  logic signed [stm_pkg::SAMPLE_W-1:0] s,
    input  logic signed [stm_pkg::SAMPLE_W-1:0] left_val,
    input  logic                            left_gt,
    input  logic signed [stm_pkg::SAMPLE_W-1:0] right_val,
    output logic signed [stm_pkg::SAMPLE_W-1:0] val,
    output logic                            gt
);
    import stm_pkg::*;

    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;

    assign gt = occ && (val_reg > s);
    assign val = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctl.shf) begin
            val_next = right_val;
        end else if (ctl.ins && (gt || tail)) begin
            val_next = left_gt ? left_val : s;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end
endmodule

>>> hdl/stm_div.sv
// restoring divider, signed dividend by unsigned count, one quotient bit per cycle
module stm_div #(
    parameter int NW = 38,
    parameter int DW = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    import stm_pkg::*;

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    mag_reg, mag_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DW:0]      rem_sh;

    always_comb begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg[DW-1:0], mag_reg[NW-1]};
        if (start) begin
            neg_next = num[NW-1];
            mag_next = num[NW-1] ? NW'(-num) : num;
            rem_next = '0;
            den_next = den;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = rem_sh - {1'b0, den_reg};
                mag_next = {mag_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                mag_next = {mag_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1)) begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo = neg_reg ? NW'(-mag_reg) : mag_reg;
endmodule

>>> hdl/stack_trimmed_mean_top.sv
// top level of the stack trimmed-mean combiner
// Takes one frame sample per transaction: while no pixel is being finished
// s_ready stays high and a sample can be accepted every cycle, inserted in
// the cell chain in the cycle it arrives. After a last-frame transaction the
// input is held off while the block computes the trim bounds, shifts the
// chain out through cell 0 up to entry hi - 1 (hi <= n), accumulating the
// kept entries, loads the divider and divides the sum by the number of kept
// entries (hi - lo) in a bit-serial divider, then presents the result. An
// empty store or an empty trim range skips the sum and the division. A
// result can wait at the output while the next pixel's samples are taken;
// a second result stalls until it is accepted.
module stack_trimmed_mean_top #(
    parameter int MAX_FRAMES = stm_pkg::MAX_FRAMES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [stm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_sample_unusable,
    input  logic                                s_last_frame,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [stm_pkg::SAMPLE_W-1:0] m_mean,
    output logic [1:0]                          m_status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);
    import stm_pkg::*;

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int IW = $clog2(MAX_FRAMES);
    localparam int SW = SAMPLE_W + IW;
    localparam int PW = FRAC_W + CW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_SUM = 3'd2;
    localparam logic [2:0] ST_DLOAD = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic signed [31:0] min_valid_reg;
    logic [FRAC_W-1:0] low_frac_reg, high_frac_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW+1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] k_reg, k_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] res_mean_reg, res_mean_next;
    logic [1:0] res_status_reg, res_status_next;
    logic m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_mean_reg, m_mean_next;
    logic [1:0] m_status_reg, m_status_next;

    logic accept, keep;
    logic [PW-1:0] lo_prod, hi_prod;
    logic [PW-1:0] hi_round;
    logic [CW+1:0] hi_raw;
    stm_ctl_t ctl;
    logic div_start, div_done;
    logic signed [SW-1:0] div_quo;

    logic signed [SAMPLE_W-1:0] cval [MAX_FRAMES];
    logic cgt [MAX_FRAMES];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign keep = !s_sample_unusable && (s_sample >= min_valid_reg)
                  && (count_reg < CW'(MAX_FRAMES));
    assign ctl.ins = accept && keep;
    assign ctl.shf = (state_reg == ST_SUM);
    assign cfg_ready = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
            logic signed [SAMPLE_W-1:0] lv, rv;
            logic lg;
            if (gi == 0) begin : g_head
                assign lv = '0;
                assign lg = 1'b0;
            end else begin : g_mid
                assign lv = cval[gi-1];
                assign lg = cgt[gi-1];
            end
            if (gi == MAX_FRAMES - 1) begin : g_end
                assign rv = cval[gi];
            end else begin : g_inner
                assign rv = cval[gi+1];
            end
            stm_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .occ      (CW'(gi) < count_reg),
                .tail     (CW'(gi) == count_reg),
                .s        (s_sample),
                .left_val (lv),
                .left_gt  (lg),
                .right_val(rv),
                .val      (cval[gi]),
                .gt       (cgt[gi])
            );
        end
    endgenerate

    assign div_start = (state_reg == ST_DLOAD);

    stm_div #(.NW(SW), .DW(CW)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (sum_reg),
        .den    (hi_reg - lo_reg[CW-1:0]),
        .done   (div_done),
        .quo    (div_quo)
    );

    // trim bounds from the stored count
    assign lo_prod = PW'(low_frac_reg) * PW'(n_reg);
    assign hi_prod = PW'(high_frac_reg) * PW'(n_reg);
    assign hi_round = hi_prod + PW'((1 << FRAC_SHIFT) - 1);
    assign hi_raw = (CW + 2)'(hi_round >> FRAC_SHIFT);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        n_next = n_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        k_next = k_reg;
        sum_next = sum_reg;
        res_mean_next = res_mean_reg;
        res_status_next = res_status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_mean_next = m_mean_reg;
        m_status_next = m_status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    count_next = count_reg + CW'(ctl.ins);
                    if (s_last_frame) begin
                        n_next = count_reg + CW'(ctl.ins);
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                count_next = '0;
                lo_next = (CW + 2)'(lo_prod >> FRAC_SHIFT);
                hi_next = (hi_raw > (CW + 2)'(n_reg)) ? n_reg : hi_raw[CW-1:0];
                k_next = '0;
                sum_next = '0;
                res_mean_next = '0;
                if (n_reg == '0) begin
                    res_status_next = STATUS_NO_VALID;
                    state_next = ST_DONE;
                end else if (lo_next >= (CW + 2)'(hi_next)) begin
                    res_status_next = STATUS_EMPTY;
                    state_next = ST_DONE;
                end else begin
                    res_status_next = STATUS_OK;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                // cell 0 holds entry k this cycle
                if ((CW + 2)'(k_reg) >= lo_reg) begin
                    sum_next = sum_reg + SW'(cval[0]);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == hi_reg - 1'b1) begin
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_mean_next = SAMPLE_W'(div_quo);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mean_next = res_mean_reg;
                    m_status_next = res_status_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
            min_valid_reg <= MIN_VALID_RST;
            low_frac_reg <= LOW_FRAC_RST;
            high_frac_reg <= HIGH_FRAC_RST;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MIN_VALID: min_valid_reg <= cfg_data;
                    REG_LOW_FRAC: low_frac_reg <= cfg_data[FRAC_W-1:0];
                    REG_HIGH_FRAC: high_frac_reg <= cfg_data[FRAC_W-1:0];
                    default: ;
                endcase
            end
        end
        n_reg <= n_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        k_reg <= k_next;
        sum_reg <= sum_next;
        res_mean_reg <= res_mean_next;
        res_status_reg <= res_status_next;
        m_mean_reg <= m_mean_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid = m_valid_reg;
    assign m_mean = m_mean_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_FRAMES))
        else $error("sample count beyond capacity");
    a_sum_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUM |-> n_reg != '0 && hi_reg != '0)
        else $error("summing an empty store");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("bad status code");
    a_calc_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CALC |=> count_reg == '0)
        else $error("store not emptied after last frame");
`endif
endmodule
